[design/mcl_pkg.sv]
// ----------------------------------------------------------------------------
// mcl_pkg
// shared constants, codes and handshake structs of the mip chain layout block
// ----------------------------------------------------------------------------
package mcl_pkg;

    localparam int DIM_BITS_DEF   = 16;
    localparam int MAX_LEVELS_DEF = 17;

    localparam int PAY_W      = 48;
    localparam int DEC_W      = 34;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 48;
    localparam int FMT_W      = 3;
    localparam int CNT_W      = 5;
    localparam int LIDX_W     = 5;
    localparam int OFF_OUT_W  = 36;
    localparam int SIZE_OUT_W = 35;
    localparam int ST_W       = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_PAYLOAD_LIMIT = 1'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_DECODED_LIMIT = 1'd1;

    localparam logic ACT_LAYOUT = 1'b0;
    localparam logic ACT_INFER  = 1'b1;

    localparam logic [FMT_W-1:0] FMT_RGBA8   = 3'd0;
    localparam logic [FMT_W-1:0] FMT_RGBA16F = 3'd1;
    localparam logic [FMT_W-1:0] FMT_R32F    = 3'd2;
    localparam logic [FMT_W-1:0] FMT_DXT1    = 3'd3;
    localparam logic [FMT_W-1:0] FMT_DXT1A   = 3'd4;
    localparam logic [FMT_W-1:0] FMT_DXT3    = 3'd5;
    localparam logic [FMT_W-1:0] FMT_DXT5    = 3'd6;
    localparam logic [FMT_W-1:0] FMT_UNKNOWN = 3'd7;

    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_LIMIT    = 3'd1;
    localparam logic [ST_W-1:0] ST_COUNT    = 3'd2;
    localparam logic [ST_W-1:0] ST_FORMAT   = 3'd3;
    localparam logic [ST_W-1:0] ST_MISMATCH = 3'd4;

    // packed field bits of one descriptor and one result
    function automatic int in_bits(input int dim);
        return 1 + FMT_W + 2 * dim + CNT_W + PAY_W + 1;
    endfunction

    function automatic int out_bits(input int dim);
        return LIDX_W + 2 * dim + OFF_OUT_W + SIZE_OUT_W + CNT_W + ST_W;
    endfunction

    function automatic int byte_round(input int bits);
        return ((bits + 7) / 8) * 8;
    endfunction

    typedef struct packed {
        logic load;
        logic size;
        logic start;
        logic reject;
        logic run;
    } ctl_cmd_t;

    typedef struct packed {
        logic            fail;
        logic [ST_W-1:0] code;
        logic            out_free;
        logic            done;
    } dp_status_t;

endpackage

[design/mcl_ctrl.sv]
// ----------------------------------------------------------------------------
// mcl_ctrl
// sequencer: descriptor capture, setup checks, level run
// ----------------------------------------------------------------------------
module mcl_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  mcl_pkg::dp_status_t status,
    output mcl_pkg::ctl_cmd_t   cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SIZE  = 4'b0010,
        S_CHECK = 4'b0100,
        S_RUN   = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SIZE;
                end
            end
            S_SIZE:
            begin
                cmd.size   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.fail)
                begin
                    if (status.out_free)
                    begin
                        cmd.reject = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = S_RUN;
                end
            end
            S_RUN:
            begin
                cmd.run = 1'b1;
                if (status.done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[design/mcl_datapath.sv]
// ----------------------------------------------------------------------------
// mcl_datapath
// descriptor registers, limit registers, level size pipeline and output beat
// ----------------------------------------------------------------------------
module mcl_datapath
#(
    parameter int DIM_BITS   = mcl_pkg::DIM_BITS_DEF,
    parameter int MAX_LEVELS = mcl_pkg::MAX_LEVELS_DEF,
    parameter int IN_W       = mcl_pkg::byte_round(mcl_pkg::in_bits(DIM_BITS)),
    parameter int OUT_W      = mcl_pkg::byte_round(mcl_pkg::out_bits(DIM_BITS))
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [IN_W-1:0]                   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [OUT_W-1:0]                  m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [mcl_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mcl_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  mcl_pkg::ctl_cmd_t                 cmd,
    output mcl_pkg::dp_status_t               status
);

    localparam int LVL_W    = $clog2(MAX_LEVELS);
    localparam int DP1      = DIM_BITS + 1;
    localparam int PROD_W   = 2 * DIM_BITS;
    localparam int SIZE_W   = 2 * DIM_BITS + 3;
    localparam int OFF_W    = 2 * DIM_BITS + 4;
    localparam int PAY_W    = mcl_pkg::PAY_W;
    localparam int CMP_W    = (OFF_W > PAY_W) ? OFF_W : PAY_W;
    localparam int D4_W     = PROD_W + 2;
    localparam int DCMP_W   = (D4_W > mcl_pkg::DEC_W) ? D4_W : mcl_pkg::DEC_W;
    localparam int OUT_BITS = mcl_pkg::out_bits(DIM_BITS);
    localparam int P_FMT    = 1;
    localparam int P_W      = P_FMT + mcl_pkg::FMT_W;
    localparam int P_H      = P_W + DIM_BITS;
    localparam int P_CNT    = P_H + DIM_BITS;
    localparam int P_PAY    = P_CNT + mcl_pkg::CNT_W;
    localparam int P_PFX    = P_PAY + PAY_W;

    // descriptor
    logic                           action_reg;
    logic [mcl_pkg::FMT_W-1:0]      fmt_reg;
    logic [mcl_pkg::CNT_W-1:0]      count_reg;
    logic [PAY_W-1:0]               payload_reg;
    logic                           prefix_reg;

    // limits
    logic [PAY_W-1:0]               payload_limit_reg;
    logic [mcl_pkg::DEC_W-1:0]      decoded_limit_reg;

    // issue stage
    logic [DIM_BITS-1:0]            w_reg;
    logic [DIM_BITS-1:0]            h_reg;
    logic [LVL_W-1:0]               lvl_reg;
    logic                           s1_valid_reg;

    // size stage
    logic [PROD_W-1:0]              prod_reg;
    logic [DIM_BITS-1:0]            s2_w_reg;
    logic [DIM_BITS-1:0]            s2_h_reg;
    logic [LVL_W-1:0]               s2_lvl_reg;
    logic                           s2_final_reg;
    logic                           s2_valid_reg;
    logic [OFF_W-1:0]               off_reg;

    // output beat
    logic                           out_valid_reg;
    logic [OUT_W-1:0]               out_data_reg;
    logic                           out_last_reg;

    logic                           adv;
    logic                           is_block;
    logic [DIM_BITS-1:0]            bw;
    logic [DIM_BITS-1:0]            bh;
    logic [DP1-1:0]                 w_p3;
    logic [DP1-1:0]                 h_p3;
    logic [DIM_BITS-1:0]            mul_a;
    logic [DIM_BITS-1:0]            mul_b;
    logic [PROD_W-1:0]              prod_next;
    logic [DIM_BITS-1:0]            w_half;
    logic [DIM_BITS-1:0]            h_half;
    logic [DIM_BITS-1:0]            w_next;
    logic [DIM_BITS-1:0]            h_next;
    logic                           s1_final;
    logic [SIZE_W-1:0]              size_c;
    logic [OFF_W-1:0]               total_c;
    logic [CMP_W-1:0]               total_x;
    logic [CMP_W-1:0]               pay_x;
    logic [CMP_W-1:0]               min_x;
    logic                           match;
    logic                           over;
    logic                           bad;
    logic                           consume;
    logic                           emit;
    logic                           lim_fail;
    logic                           dec_fail;
    logic                           cnt_fail;
    logic [DIM_BITS-1:0]            max_wh;
    logic                           count_fits;
    logic                           out_load;
    logic [mcl_pkg::LIDX_W-1:0]     o_idx;
    logic [DIM_BITS-1:0]            o_w;
    logic [DIM_BITS-1:0]            o_h;
    logic [mcl_pkg::OFF_OUT_W-1:0]  o_off;
    logic [mcl_pkg::SIZE_OUT_W-1:0] o_size;
    logic [mcl_pkg::CNT_W-1:0]      o_found;
    logic [mcl_pkg::ST_W-1:0]       o_status;
    logic                           o_last;
    logic [OUT_BITS-1:0]            o_packed;

    assign adv = !out_valid_reg || m_tready;

    // shared multiplier: base area for the decoded check, then one level each time the run pipeline advances
    always_comb
    begin
        is_block = (fmt_reg >= mcl_pkg::FMT_DXT1);
        w_p3     = DP1'(w_reg) + DP1'(3);
        h_p3     = DP1'(h_reg) + DP1'(3);
        bw       = DIM_BITS'(w_p3[DP1-1:2]);
        bh       = DIM_BITS'(h_p3[DP1-1:2]);
        if (cmd.run && is_block)
        begin
            mul_a = bw;
            mul_b = bh;
        end
        else
        begin
            mul_a = w_reg;
            mul_b = h_reg;
        end
        prod_next = PROD_W'(mul_a) * PROD_W'(mul_b);
        w_half    = w_reg >> 1;
        h_half    = h_reg >> 1;
        w_next    = (w_half == '0) ? DIM_BITS'(1) : w_half;
        h_next    = (h_half == '0) ? DIM_BITS'(1) : h_half;
        if (action_reg == mcl_pkg::ACT_INFER)
        begin
            s1_final = ((w_reg == DIM_BITS'(1)) && (h_reg == DIM_BITS'(1)))
                       || (32'(lvl_reg) == MAX_LEVELS - 1);
        end
        else
        begin
            s1_final = (32'(lvl_reg) + 32'd1) == 32'(count_reg);
        end
    end

    // setup checks, valid in the check cycle
    always_comb
    begin
        dec_fail   = DCMP_W'({prod_reg, 2'b00}) > DCMP_W'(decoded_limit_reg);
        lim_fail   = (action_reg == mcl_pkg::ACT_LAYOUT)
                     && ((payload_reg > payload_limit_reg) || dec_fail);
        max_wh     = (w_reg > h_reg) ? w_reg : h_reg;
        count_fits = (max_wh >> (count_reg - mcl_pkg::CNT_W'(1))) != '0;
        cnt_fail   = (action_reg == mcl_pkg::ACT_LAYOUT)
                     && ((count_reg == '0) || (32'(count_reg) > MAX_LEVELS) || !count_fits);
        status.fail     = 1'b1;
        status.code     = mcl_pkg::ST_OK;
        priority if (lim_fail)
        begin
            status.code = mcl_pkg::ST_LIMIT;
        end
        else if (fmt_reg == mcl_pkg::FMT_UNKNOWN)
        begin
            status.code = mcl_pkg::ST_FORMAT;
        end
        else if ((w_reg == '0) || (h_reg == '0) || cnt_fail)
        begin
            status.code = mcl_pkg::ST_COUNT;
        end
        else
        begin
            status.fail = 1'b0;
        end
        status.out_free = adv;
        status.done     = consume && emit
                          && ((action_reg == mcl_pkg::ACT_INFER) || s2_final_reg);
    end

    // level size, running offset and extent compare
    always_comb
    begin
        unique case (fmt_reg)
            mcl_pkg::FMT_RGBA8,
            mcl_pkg::FMT_R32F:
            begin
                size_c = SIZE_W'({prod_reg, 2'b00});
            end
            mcl_pkg::FMT_RGBA16F,
            mcl_pkg::FMT_DXT1,
            mcl_pkg::FMT_DXT1A:
            begin
                size_c = SIZE_W'({prod_reg, 3'b000});
            end
            default:
            begin
                size_c = SIZE_W'({prod_reg, 4'b0000});
            end
        endcase
        total_c = off_reg + OFF_W'(size_c);
        total_x = CMP_W'(total_c);
        pay_x   = CMP_W'(payload_reg);
        min_x   = (total_x < pay_x) ? total_x : pay_x;
        match   = (total_x == pay_x);
        over    = (total_x > pay_x);
        bad     = prefix_reg ? (total_x >= pay_x) : !match;
        consume = cmd.run && adv && s2_valid_reg;
        if (action_reg == mcl_pkg::ACT_INFER)
        begin
            emit = match || over || s2_final_reg;
        end
        else
        begin
            emit = 1'b1;
        end
        out_load    = cmd.reject || (consume && emit);
    end

    // result beat
    always_comb
    begin
        o_idx    = '0;
        o_w      = '0;
        o_h      = '0;
        o_off    = '0;
        o_size   = '0;
        o_found  = '0;
        o_status = mcl_pkg::ST_OK;
        o_last   = 1'b1;
        if (cmd.reject)
        begin
            o_status = status.code;
        end
        else if (action_reg == mcl_pkg::ACT_INFER)
        begin
            if (match)
            begin
                o_found = mcl_pkg::CNT_W'(s2_lvl_reg) + mcl_pkg::CNT_W'(1);
                o_off   = mcl_pkg::OFF_OUT_W'(payload_reg);
            end
            else
            begin
                o_off    = mcl_pkg::OFF_OUT_W'(min_x);
                o_status = mcl_pkg::ST_MISMATCH;
            end
        end
        else
        begin
            o_idx  = mcl_pkg::LIDX_W'(s2_lvl_reg);
            o_w    = s2_w_reg;
            o_h    = s2_h_reg;
            o_size = mcl_pkg::SIZE_OUT_W'(size_c);
            o_last = s2_final_reg;
            if (s2_final_reg && bad)
            begin
                o_off    = mcl_pkg::OFF_OUT_W'(min_x);
                o_status = mcl_pkg::ST_MISMATCH;
            end
            else
            begin
                o_off = mcl_pkg::OFF_OUT_W'(off_reg);
            end
        end
        o_packed = {o_status, o_found, o_size, o_off, o_h, o_w, o_idx};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            payload_limit_reg <= '1;
            decoded_limit_reg <= '1;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (cfg_addr)
                    mcl_pkg::REG_PAYLOAD_LIMIT:
                    begin
                        payload_limit_reg <= cfg_wdata[PAY_W-1:0];
                    end
                    mcl_pkg::REG_DECODED_LIMIT:
                    begin
                        decoded_limit_reg <= cfg_wdata[mcl_pkg::DEC_W-1:0];
                    end
                    default:
                    begin
                        payload_limit_reg <= payload_limit_reg;
                    end
                endcase
            end
            if (cmd.start)
            begin
                s1_valid_reg <= 1'b1;
                s2_valid_reg <= 1'b0;
            end
            else if (cmd.run && adv)
            begin
                s2_valid_reg <= s1_valid_reg;
                if (s1_valid_reg && s1_final)
                begin
                    s1_valid_reg <= 1'b0;
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg  <= s_tdata[0];
            fmt_reg     <= s_tdata[P_FMT +: mcl_pkg::FMT_W];
            w_reg       <= s_tdata[P_W +: DIM_BITS];
            h_reg       <= s_tdata[P_H +: DIM_BITS];
            count_reg   <= s_tdata[P_CNT +: mcl_pkg::CNT_W];
            payload_reg <= s_tdata[P_PAY +: PAY_W];
            prefix_reg  <= s_tdata[P_PFX];
        end
        if (cmd.size)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.start)
        begin
            lvl_reg <= '0;
            off_reg <= '0;
        end
        else if (cmd.run && adv)
        begin
            if (s1_valid_reg)
            begin
                prod_reg     <= prod_next;
                s2_w_reg     <= w_reg;
                s2_h_reg     <= h_reg;
                s2_lvl_reg   <= lvl_reg;
                s2_final_reg <= s1_final;
                w_reg        <= w_next;
                h_reg        <= h_next;
                lvl_reg      <= lvl_reg + LVL_W'(1);
            end
            if (s2_valid_reg)
            begin
                off_reg <= total_c;
            end
        end
        if (out_load)
        begin
            out_data_reg <= OUT_W'(o_packed);
            out_last_reg <= o_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

[design/mip_chain_layout.sv]
// ----------------------------------------------------------------------------
// mip_chain_layout
// mipmap chain size and offset calculator, one texture descriptor per beat
// ----------------------------------------------------------------------------
// input stream: one descriptor beat (action, format, base size, level count,
// payload byte count, prefix mode). output stream: one beat per mip level in
// layout mode, tlast on the final one; a single beat for a rejected
// descriptor or in infer mode.
// config port: payload_limit (index 0) and decoded_limit (index 1); both
// reset to all ones. the user must see that they are written only while the
// block is idle; the block itself does not enforce it.
// the descriptor is taken in the idle state, the base area is multiplied in
// the size state and the setup checks are made in the check state. levels
// then go through a two-stage multiply and accumulate pipeline at one level
// per cycle while the output is not stalled; infer mode walks the chain the
// same way until it matches or overruns the payload or hits its last level.
// one descriptor is in work at a time; the next is taken once the last beat
// of the current one sits in the output register.
// a stalled output holds its beat and freezes the level pipeline.
// reset clears the sequencer, the pipeline valids and the output valid.
// ----------------------------------------------------------------------------
module mip_chain_layout
#(
    parameter int DIM_BITS   = mcl_pkg::DIM_BITS_DEF,
    parameter int MAX_LEVELS = mcl_pkg::MAX_LEVELS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // action, pixel_format, base_width, base_height, level_count,
    // payload_bytes, prefix_mode
    input  logic [mcl_pkg::byte_round(mcl_pkg::in_bits(DIM_BITS))-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // level_index, level_width, level_height, byte_offset, byte_size,
    // found_count, status
    output logic [mcl_pkg::byte_round(mcl_pkg::out_bits(DIM_BITS))-1:0] m_tdata,
    output logic                           m_tlast,
    input  logic                           cfg_wr_en,
    input  logic [mcl_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [mcl_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    mcl_pkg::ctl_cmd_t   cmd;
    mcl_pkg::dp_status_t status;

    mcl_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    mcl_datapath
    #(
        .DIM_BITS   (DIM_BITS),
        .MAX_LEVELS (MAX_LEVELS)
    )
    u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[design/mcl_checker.sv]
// ----------------------------------------------------------------------------
// mcl_checker
// port-level checks of the mip chain layout block, bound to the top level
// ----------------------------------------------------------------------------
module mcl_checker
#(
    parameter int DIM_BITS = mcl_pkg::DIM_BITS_DEF
)
(
    input logic                                                         clk,
    input logic                                                         rst_n,
    input logic                                                         s_tvalid,
    input logic                                                         s_tready,
    input logic                                                         m_tvalid,
    input logic                                                         m_tready,
    input logic [mcl_pkg::byte_round(mcl_pkg::out_bits(DIM_BITS))-1:0]  m_tdata,
    input logic                                                         m_tlast
);

    localparam int P_FOUND  = mcl_pkg::LIDX_W + 2 * DIM_BITS + mcl_pkg::OFF_OUT_W
                              + mcl_pkg::SIZE_OUT_W;
    localparam int P_STATUS = P_FOUND + mcl_pkg::CNT_W;

    logic [mcl_pkg::CNT_W-1:0] found;
    logic [mcl_pkg::ST_W-1:0]  st;

    assign found = m_tdata[P_FOUND +: mcl_pkg::CNT_W];
    assign st    = m_tdata[P_STATUS +: mcl_pkg::ST_W];

    // one descriptor in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("descriptor taken in back-to-back cycles");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled beat changed");

    // any error ends the item
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (st != mcl_pkg::ST_OK) |-> m_tlast)
        else $error("error beat without tlast");

    a_mid_beat: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (found == '0) && (st == mcl_pkg::ST_OK))
        else $error("inner level beat carries count or status");

endmodule

bind mip_chain_layout mcl_checker
#(
    .DIM_BITS (DIM_BITS)
)
u_mcl_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
